### hdl/vnos_pkg.sv
`timescale 1ns / 1ps
// vnos_pkg: constants shared by the value noise octave shader core.
// No dependencies.
package vnos_pkg;

   localparam int unsigned ZOOM_FRAC = 16;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W = 32;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_INVERSE_ZOOM = 2'd0;
   localparam csr_index_type CSR_PERSISTENCE = 2'd1;
   localparam csr_index_type CSR_HASH_SEED = 2'd2;

   localparam logic [19:0] INVERSE_ZOOM_RST = 20'd2048;
   localparam logic [15:0] PERSISTENCE_RST = 16'd16384;
   localparam logic [31:0] HASH_SEED_RST = 32'd0;

   // hash constants, Q30 one and octave amplitude scale
   localparam logic [31:0] HASH_MUL_Y = 32'd57;
   localparam logic [31:0] HASH_MUL_Z = 32'd115;
   localparam int unsigned HASH_SHIFT = 13;
   localparam logic [31:0] HASH_C1 = 32'd60493;
   localparam logic [31:0] HASH_C2 = 32'd19990303;
   localparam logic [31:0] HASH_C3 = 32'd1376312589;
   localparam logic [31:0] Q30_ONE = 32'd1073741824;
   localparam int unsigned AMP_ONE = 32768;
   localparam int unsigned AMP_FRAC = 15;

   // weight table generation, Q30 Taylor series of sin
   localparam logic [63:0] PI_Q30 = 64'd3373259426;
   localparam logic [63:0] TAYLOR_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                               64'd156, 64'd210};

endpackage

### hdl/value_noise_octave_shader_core.sv
`timescale 1ns / 1ps
// value_noise_octave_shader_core: pipelined multi-octave lattice value noise shader.
// Depends on vnos_pkg.
//
// Usage:
//   req_* carries one pixel per transfer: x_coord, y_coord and layer.
//   rsp_* returns one gray level per pixel, in request order.
//   csr_* writes inverse_zoom, persistence and hash_seed; write only while idle.
// Pipeline: the input register loads at the request transfer edge, then come
//   13 more pipeline stages, then the output register.
// Throughput: one pixel per cycle while req_tready is high. Every octave has its
//   own lane of corner hashes (three 32-bit multiply stages) and blends; the lanes
//   run in parallel and all stages advance together.
// Reset: clears all valid bits and loads the register defaults; the octave
//   amplitude chain has no reset and settles through its registers well ahead
//   of the first pixel reaching it.
// Stall: a two-entry output buffer (output register plus skid) absorbs a
//   held rsp_tready; req_tready drops only once the skid entry is occupied, and
//   the pipeline then holds every stage until the skid drains.
module value_noise_octave_shader_core
   import vnos_pkg::*;
#(
   parameter int unsigned OCTAVE_COUNT = 3,
   parameter int unsigned FRACTION_BITS = 16,
   parameter int unsigned WEIGHT_TABLE_DEPTH = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [63:0]            req_tdata,   // x_coord[23:0], y_coord[47:24], layer[63:48]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,   // gray_level[7:0]
   input  logic                   csr_wr_en,
   input  csr_index_type          csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   localparam int unsigned UP = (FRACTION_BITS > ZOOM_FRAC) ? FRACTION_BITS - ZOOM_FRAC : 0;
   localparam int unsigned DN = (FRACTION_BITS < ZOOM_FRAC) ? ZOOM_FRAC - FRACTION_BITS : 0;
   localparam int unsigned P_W = 45;
   localparam int unsigned C_W = P_W + OCTAVE_COUNT + UP + 32;
   localparam int unsigned IDX_W = $clog2(WEIGHT_TABLE_DEPTH);
   localparam int unsigned FP_W = FRACTION_BITS + IDX_W + 1;
   localparam int unsigned AMP_W = 16 + OCTAVE_COUNT;
   localparam int unsigned TERM_W = 32 + AMP_W + 1 - AMP_FRAC;
   localparam int unsigned SUM_W = TERM_W + $clog2(OCTAVE_COUNT) + 1;
   localparam int unsigned M_W = SUM_W + 10;
   localparam int unsigned G_W = M_W - 31;
   localparam int unsigned LAST = 14;

   function automatic logic [16:0] weight_calc(input int unsigned idx);
      logic [63:0] phi;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] s;
      logic [63:0] s2;
      longint      acc;
      phi = PI_Q30 * 64'(idx) / 64'(2 * WEIGHT_TABLE_DEPTH);
      x2 = (phi * phi) >> 30;
      term = phi;
      acc = longint'(phi);
      for (int k = 1; k <= 7; k++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[k];
         if (k % 2 == 1) acc = acc - longint'(term);
         else acc = acc + longint'(term);
      end
      s = (acc < 0) ? 64'd0 : 64'(acc);
      s2 = (s * s) >> 30;
      return 17'((s2 + 64'd8192) >> 14);
   endfunction

   function automatic logic [30:0] r7_calc(input logic [31:0] n, input logic [31:0] q);
      logic [31:0] r;
      r = n * q + HASH_C3;
      return r[30:0];
   endfunction

   logic [16:0] weight_rom [WEIGHT_TABLE_DEPTH];

   for (genvar gw = 0; gw < WEIGHT_TABLE_DEPTH; gw++) begin : g_wt
      assign weight_rom[gw] = weight_calc(gw);
   end

   // configuration
   logic [19:0] zoom_ff;
   logic [15:0] pers_ff;
   logic [31:0] seed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         zoom_ff <= INVERSE_ZOOM_RST;
         pers_ff <= PERSISTENCE_RST;
         seed_ff <= HASH_SEED_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_INVERSE_ZOOM: zoom_ff <= csr_wr_data[19:0];
            CSR_PERSISTENCE:  pers_ff <= csr_wr_data[15:0];
            CSR_HASH_SEED:    seed_ff <= csr_wr_data[31:0];
            default: ;
         endcase
      end
   end

   // octave amplitudes, follow persistence
   logic [AMP_W-1:0] amp_ff [OCTAVE_COUNT];

   always_ff @(posedge clock) begin
      amp_ff[0] <= AMP_W'(AMP_ONE);
      for (int o = 1; o < OCTAVE_COUNT; o++) begin
         amp_ff[o] <= AMP_W'(((AMP_W + 16)'(amp_ff[o-1]) * (AMP_W + 16)'(pers_ff)) >> AMP_FRAC);
      end
   end

   // pipeline control
   logic             en;
   logic             push;
   logic [LAST:1]    v_ff;
   logic             rsp_valid_ff;
   logic             skid_valid_ff;
   logic [7:0]       rsp_data_ff;
   logic [7:0]       skid_data_ff;
   logic [7:0]       gray_in;

   assign en = !skid_valid_ff;
   assign req_tready = en;
   assign push = en && v_ff[LAST];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[LAST-1:1], req_tvalid};
      end
   end

   // S1: input capture
   logic signed [23:0] x1_ff;
   logic signed [23:0] y1_ff;
   logic signed [15:0] z1_ff;

   // S2: scaled position and hash mix
   logic signed [P_W-1:0] px2_ff;
   logic signed [P_W-1:0] py2_ff;
   logic [31:0]           zmix2_ff;
   logic [31:0]           zmix3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff <= req_tdata[23:0];
         y1_ff <= req_tdata[47:24];
         z1_ff <= req_tdata[63:48];
         px2_ff <= P_W'(x1_ff) * $signed(P_W'({1'b0, zoom_ff}));
         py2_ff <= P_W'(y1_ff) * $signed(P_W'({1'b0, zoom_ff}));
         zmix2_ff <= seed_ff + 32'(32'(z1_ff) * $signed(HASH_MUL_Z));
         zmix3_ff <= zmix2_ff;
      end
   end

   logic signed [TERM_W-1:0] term_ff [OCTAVE_COUNT];

   for (genvar go = 0; go < OCTAVE_COUNT; go++) begin : g_oct
      localparam int unsigned SH = go + UP;

      logic signed [C_W-1:0]  xpos;
      logic signed [C_W-1:0]  ypos;
      logic [FP_W-1:0]        xfp;
      logic [FP_W-1:0]        yfp;
      logic [31:0]            cx3_ff;
      logic [31:0]            cy3_ff;
      logic [IDX_W-1:0]       ix3_ff;
      logic [IDX_W-1:0]       iy3_ff;
      logic [31:0]            n4_in [4];
      logic [31:0]            n4_ff [4];
      logic [31:0]            n5_ff [4];
      logic [31:0]            sq5_ff [4];
      logic [31:0]            n6_ff [4];
      logic [31:0]            q6_ff [4];
      logic signed [31:0]     cor7_ff [4];
      logic [16:0]            wx_ff [4:8];
      logic [16:0]            wy_ff [4:10];
      logic signed [32:0]     dt8_ff;
      logic signed [32:0]     db8_ff;
      logic signed [31:0]     at8_ff;
      logic signed [31:0]     ab8_ff;
      logic signed [50:0]     pt9;
      logic signed [50:0]     pb9;
      logic signed [31:0]     top9_ff;
      logic signed [31:0]     bot9_ff;
      logic signed [32:0]     dz10_ff;
      logic signed [31:0]     tz10_ff;
      logic signed [50:0]     pz11;
      logic signed [31:0]     nz11_ff;
      logic signed [32+AMP_W:0] pa12;

      assign xpos = (C_W'(px2_ff) <<< SH) >>> DN;
      assign ypos = (C_W'(py2_ff) <<< SH) >>> DN;
      assign xfp = FP_W'(xpos[FRACTION_BITS-1:0]) * FP_W'(WEIGHT_TABLE_DEPTH);
      assign yfp = FP_W'(ypos[FRACTION_BITS-1:0]) * FP_W'(WEIGHT_TABLE_DEPTH);

      always_comb begin
         for (int k = 0; k < 4; k++) begin
            n4_in[k] = ((cx3_ff + 32'(k % 2)) + (cy3_ff + 32'(k / 2)) * HASH_MUL_Y) ^ zmix3_ff;
            n4_in[k] = (n4_in[k] << HASH_SHIFT) ^ n4_in[k];
         end
      end

      assign pt9 = dt8_ff * $signed({34'd0, wx_ff[8]});
      assign pb9 = db8_ff * $signed({34'd0, wx_ff[8]});
      assign pz11 = dz10_ff * $signed({34'd0, wy_ff[10]});
      assign pa12 = nz11_ff * $signed({1'b0, amp_ff[go]});

      always_ff @(posedge clock) begin
         if (en) begin
            cx3_ff <= xpos[FRACTION_BITS+31:FRACTION_BITS];
            cy3_ff <= ypos[FRACTION_BITS+31:FRACTION_BITS];
            ix3_ff <= xfp[FRACTION_BITS+IDX_W-1:FRACTION_BITS];
            iy3_ff <= yfp[FRACTION_BITS+IDX_W-1:FRACTION_BITS];
            wx_ff[4] <= weight_rom[ix3_ff];
            wy_ff[4] <= weight_rom[iy3_ff];
            for (int s = 5; s <= 8; s++) wx_ff[s] <= wx_ff[s-1];
            for (int s = 5; s <= 10; s++) wy_ff[s] <= wy_ff[s-1];
            for (int k = 0; k < 4; k++) begin
               n4_ff[k] <= n4_in[k];
               n5_ff[k] <= n4_ff[k];
               sq5_ff[k] <= n4_ff[k] * n4_ff[k];
               n6_ff[k] <= n5_ff[k];
               q6_ff[k] <= sq5_ff[k] * HASH_C1 + HASH_C2;
               cor7_ff[k] <= $signed(Q30_ONE - {1'b0, r7_calc(n6_ff[k], q6_ff[k])});
            end
            dt8_ff <= 33'(cor7_ff[1]) - 33'(cor7_ff[0]);
            db8_ff <= 33'(cor7_ff[3]) - 33'(cor7_ff[2]);
            at8_ff <= cor7_ff[0];
            ab8_ff <= cor7_ff[2];
            top9_ff <= at8_ff + 32'(pt9 >>> 16);
            bot9_ff <= ab8_ff + 32'(pb9 >>> 16);
            dz10_ff <= 33'(bot9_ff) - 33'(top9_ff);
            tz10_ff <= top9_ff;
            nz11_ff <= tz10_ff + 32'(pz11 >>> 16);
            term_ff[go] <= TERM_W'(pa12 >>> AMP_FRAC);
         end
      end
   end

   // S13: octave sum, S14: byte scaling
   logic signed [SUM_W-1:0] sum_in;
   logic signed [SUM_W-1:0] sum13_ff;
   logic signed [M_W-1:0]   t14;
   logic signed [M_W-1:0]   m14;
   logic signed [G_W-1:0]   g14_ff;

   always_comb begin
      sum_in = '0;
      for (int o = 0; o < OCTAVE_COUNT; o++) sum_in = sum_in + SUM_W'(term_ff[o]);
   end

   assign t14 = M_W'(sum13_ff) + $signed(M_W'(Q30_ONE));
   assign m14 = (t14 <<< 8) - t14;

   always_ff @(posedge clock) begin
      if (en) begin
         sum13_ff <= sum_in;
         g14_ff <= G_W'(m14 >>> 31);
      end
   end

   always_comb begin
      if (g14_ff < 0) gray_in = 8'd0;
      else if (g14_ff > $signed(G_W'(255))) gray_in = 8'd255;
      else gray_in = g14_ff[7:0];
   end

   // output register and skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (rsp_tready || !rsp_valid_ff) begin
         if (skid_valid_ff) begin
            rsp_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= push;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_tready || !rsp_valid_ff) begin
         rsp_data_ff <= skid_valid_ff ? skid_data_ff : gray_in;
      end else if (push) begin
         skid_data_ff <= gray_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule

### bench/value_noise_octave_shader_core_test.sv
`timescale 1ns / 1ps
// value_noise_octave_shader_core_test: self-checking bench for the value noise shader core.
// Predicts every gray level from its own model of the octave noise; depends on vnos_pkg.
module value_noise_octave_shader_core_test;
   import vnos_pkg::*;

   typedef struct {
      logic signed [23:0] x_coord;
      logic signed [23:0] y_coord;
      logic signed [15:0] layer;
   } pixel_type;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 30;
   localparam int PHASE_ITEMS = 175;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [63:0] req_tdata = '0;          // x_coord[23:0], y_coord[47:24], layer[63:48]
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;                // gray_level[7:0]
   logic csr_wr_en = 1'b0;
   csr_index_type csr_index = CSR_INVERSE_ZOOM;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   value_noise_octave_shader_core DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // shadow registers
   logic [19:0] zoom_shadow = INVERSE_ZOOM_RST;
   logic [15:0] persist_shadow = PERSISTENCE_RST;
   logic [31:0] seed_shadow = HASH_SEED_RST;

   longint weight_q16 [256];
   pixel_type pending_pixels [$];
   logic [7:0] gray_expected [$];
   int error_count = 0;
   int req_count = 0;
   int rsp_count = 0;
   int idle_cycles = 0;

   function automatic longint unsigned sine_q30(longint unsigned ang);
      longint unsigned sq, term;
      longint acc;
      longint unsigned div;
      sq = (ang * ang) >> 30;
      term = ang;
      acc = longint'(ang);
      for (int k = 1; k <= 7; k++) begin
         div = longint'((2 * k) * (2 * k + 1));
         term = ((term * sq) >> 30) / div;
         if (k % 2 == 1) acc = acc - longint'(term);
         else acc = acc + longint'(term);
      end
      return (acc < 0) ? 64'd0 : longint'(acc);
   endfunction

   function automatic longint corner_q30(logic [31:0] cx, logic [31:0] cy, logic [31:0] zmix);
      logic [31:0] n, nn;
      n = (cx + cy * 32'd57) ^ zmix;
      n = (n << 13) ^ n;
      nn = (n * (n * n * 32'd60493 + 32'd19990303) + 32'd1376312589) & 32'h7fffffff;
      return 64'sd1073741824 - longint'({32'b0, nn});
   endfunction

   function automatic longint lerp_cos(longint a, longint b, longint w);
      return (a * (64'sd65536 - w) + b * w) >>> 16;
   endfunction

   function automatic logic [7:0] gray_of(pixel_type p);
      logic [31:0] zmix, cx, cy;
      longint amp, acc, scale, cxp, cyp, wx, wy, top, bot, nz, g;
      zmix = seed_shadow + {{16{p.layer[15]}}, p.layer} * 32'd115;
      amp = 32768;
      acc = 0;
      for (int oct = 0; oct < 3; oct++) begin
         scale = longint'({44'b0, zoom_shadow}) << oct;
         cxp = longint'(p.x_coord) * scale;
         cyp = longint'(p.y_coord) * scale;
         cx = 32'(cxp >>> 16);
         cy = 32'(cyp >>> 16);
         wx = weight_q16[cxp[15:8]];
         wy = weight_q16[cyp[15:8]];
         top = lerp_cos(corner_q30(cx, cy, zmix), corner_q30(cx + 32'd1, cy, zmix), wx);
         bot = lerp_cos(corner_q30(cx, cy + 32'd1, zmix),
                        corner_q30(cx + 32'd1, cy + 32'd1, zmix), wx);
         nz = lerp_cos(top, bot, wy);
         acc = acc + ((nz * amp) >>> 15);
         amp = (amp * longint'({48'b0, persist_shadow})) >>> 15;
      end
      g = ((acc + 64'sd1073741824) * 255) >>> 31;
      if (g < 0) g = 0;
      if (g > 255) g = 255;
      return 8'(g);
   endfunction

   function automatic logic [23:0] random_coord();
      case ($urandom_range(0, 3))
         0: return 24'($urandom);
         1: return 24'($signed($urandom_range(0, 8192)) - 4096);
         2: return ($urandom_range(0, 1)) ? 24'h7fffff - 24'($urandom_range(0, 15))
                                          : 24'h800000 + 24'($urandom_range(0, 15));
         default: return 24'($signed($urandom_range(0, 600)) - 300);
      endcase
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type p;
      p.x_coord = random_coord();
      p.y_coord = random_coord();
      p.layer = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($signed($urandom_range(0, 20)) - 10);
      return p;
   endfunction

   function automatic pixel_type make_pixel(int x, int y, int z);
      pixel_type p;
      p.x_coord = 24'(x);
      p.y_coord = 24'(y);
      p.layer = 16'(z);
      return p;
   endfunction

   // driver: bursts with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_tready)) begin
         pixel_type p;
         if (req_tvalid) begin
            p.x_coord = req_tdata[23:0];
            p.y_coord = req_tdata[47:24];
            p.layer = req_tdata[63:48];
            gray_expected.push_back(gray_of(p));
            req_count++;
         end
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_pixels.size() > 0) begin
            p = pending_pixels.pop_front();
            req_tdata <= {p.layer, p.y_coord, p.x_coord};
            req_tvalid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor: own stall pattern, one long hold-off
   int hold_left = 0;
   int mode_left = 0;
   bit stall_mode = 1'b0;
   bit long_hold_done = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_count++;
            if (gray_expected.size() == 0) begin
               $error("unexpected transfer: gray_level actual %0d", rsp_tdata);
               error_count++;
            end else begin
               logic [7:0] want;
               want = gray_expected.pop_front();
               if (want !== rsp_tdata) begin
                  $error("gray_level mismatch: expected %0d actual %0d", want, rsp_tdata);
                  error_count++;
               end
            end
            if (rsp_count == 200 && !long_hold_done) begin
               long_hold_done = 1'b1;
               hold_left = 400;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode_left = $urandom_range(10, 80);
               stall_mode = $urandom_range(0, 2) != 0;
            end
            mode_left--;
            rsp_tready <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic write_csr(csr_index_type idx, logic [31:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_INVERSE_ZOOM: zoom_shadow = data[19:0];
         CSR_PERSISTENCE: persist_shadow = data[15:0];
         CSR_HASH_SEED: seed_shadow = data;
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      while (pending_pixels.size() > 0 || req_tvalid || gray_expected.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [19:0] zooms [8];
      logic [15:0] persists [8];
      logic [31:0] seeds [8];
      for (int i = 0; i < 256; i++)
         weight_q16[i] = longint'((((sine_q30((64'd3373259426 * i) / 512) ** 2) >> 30)
                                    + 8192) >> 14);
      zooms = '{20'd2048, 20'd1, 20'hfffff, 20'd0, 20'd65536, 20'd0, 20'd0, 20'd0};
      persists = '{16'd16384, 16'd32768, 16'd0, 16'd65535, 16'd32768, 16'd0, 16'd0, 16'd0};
      seeds = '{32'd0, 32'h7fffffff, 32'h80000000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 8; ph++) begin
         if (ph >= 3) seeds[ph] = $urandom;
         if (ph >= 5) begin
            zooms[ph] = (ph == 7) ? 20'($urandom_range(1, 20'hfffff))
                                  : 20'($urandom_range(1, 4096));
            persists[ph] = 16'($urandom_range(0, 32768));
         end
         if (ph > 0) begin
            write_csr(CSR_INVERSE_ZOOM, (ph == 4) ? {12'hfff, zooms[ph]} : {12'b0, zooms[ph]});
            write_csr(CSR_PERSISTENCE, (ph == 4) ? {16'hffff, persists[ph]}
                                                 : {16'b0, persists[ph]});
            write_csr(CSR_HASH_SEED, seeds[ph]);
            if (ph == 4) write_csr(csr_index_type'(3), $urandom);
         end
         if (ph == 0 || ph == 3) begin
            pending_pixels.push_back(make_pixel(0, 0, 0));
            pending_pixels.push_back(make_pixel(8388607, 8388607, 32767));
            pending_pixels.push_back(make_pixel(-8388608, -8388608, -32768));
            pending_pixels.push_back(make_pixel(-1, -1, -1));
            pending_pixels.push_back(make_pixel(1, -1, 0));
            pending_pixels.push_back(make_pixel(-8388608, 8388607, 0));
            pending_pixels.push_back(make_pixel(8388607, -8388608, 32767));
            pending_pixels.push_back(make_pixel(-32, 32, -32768));
            pending_pixels.push_back(make_pixel(-33, -31, 5));
            pending_pixels.push_back(make_pixel(4096, -4096, 1));
            pending_pixels.push_back(make_pixel(-100, 37, -5));
            pending_pixels.push_back(make_pixel(31, 33, 100));
         end
         for (int i = 0; i < PHASE_ITEMS; i++) pending_pixels.push_back(random_pixel());
         wait_idle();
      end
      $display("covered %0d pixel transfers over 8 register settings, %0d results checked",
               req_count, rsp_count);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
